// ----- hdl/mcg_pkg.sv -----
// mcg_pkg: types, constants and saturating Q32.32 helpers for the call payoff/greeks pipeline
// no dependencies; used by the interfaces, the arithmetic units and the top level
`default_nettype none

package mcg_pkg;

    localparam int LAT_MUL   = 2;
    localparam int DIV_STEPS = 96;
    localparam int LAT_DIV   = DIV_STEPS + 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic signed [63:0] Q_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] Q_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] Q_HALF = 64'sh0000_0000_8000_0000;
    localparam logic [62:0]        Q_ONE  = 63'h0000_0001_0000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STRIKE   = 3'd0,
        CFG_MATURITY = 3'd1,
        CFG_RATE     = 3'd2,
        CFG_DISCOUNT = 3'd3,
        CFG_MODE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [62:0]        terminal_price;
        logic [62:0]        start_price;
        logic [62:0]        volatility;
        logic signed [63:0] brownian_value;
    } path_t;

    typedef struct packed {
        logic signed [63:0] payoff;
        logic signed [63:0] delta;
        logic signed [63:0] gamma;
        logic signed [63:0] vega;
        logic signed [63:0] theta;
        logic signed [63:0] rho;
        logic               divide_fault;
    } greeks_t;

    typedef struct packed {
        logic [62:0]        s;
        logic [62:0]        s0;
        logic [62:0]        v;
        logic signed [63:0] w;
        logic               itm;
    } side_t;

    typedef struct packed {
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] r;
        logic [63:0] q;
        logic        over;
        logic        neg;
        logic        zero;
    } div_stage_t;

    function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
        logic signed [63:0] res;
        if (!neg)
        begin
            res = m[63] ? Q_MAX : signed'(m);
        end
        else
        begin
            res = m[63] ? Q_MIN : -signed'(m);
        end
        return res;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] sum;
        logic signed [63:0] res;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63])
        begin
            res = sum[64] ? Q_MIN : Q_MAX;
        end
        else
        begin
            res = signed'(sum[63:0]);
        end
        return res;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] diff;
        logic signed [63:0] res;
        diff = {a[63], a} - {b[63], b};
        if (diff[64] != diff[63])
        begin
            res = diff[64] ? Q_MIN : Q_MAX;
        end
        else
        begin
            res = signed'(diff[63:0]);
        end
        return res;
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

    function automatic logic signed [63:0] uq(input logic [62:0] x);
        return signed'({1'b0, x});
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mcg_path_if.sv -----
// mcg_path_if: request channel carrying one simulated path
// depends on mcg_pkg
`default_nettype none

interface mcg_path_if;
    import mcg_pkg::*;

    logic  valid;
    logic  ready;
    path_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/mcg_greek_if.sv -----
// mcg_greek_if: result channel carrying payoff and greek estimates
// depends on mcg_pkg
`default_nettype none

interface mcg_greek_if;
    import mcg_pkg::*;

    logic    valid;
    logic    ready;
    greeks_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/mcg_qmul.sv -----
// mcg_qmul: two-stage saturating Q32.32 multiplier built from four 32x32 partial products
// depends on mcg_pkg
`default_nettype none

module mcg_qmul (
    input  logic              clk,
    input  logic              en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);
    import mcg_pkg::*;

    logic [63:0]        ua;
    logic [63:0]        ub;
    logic               neg_reg;
    logic [63:0]        p00_reg;
    logic [63:0]        p01_reg;
    logic [63:0]        p10_reg;
    logic [63:0]        p11_reg;
    logic [33:0]        mid;
    logic [65:0]        hi;
    logic [63:0]        mag;
    logic signed [63:0] p_next;
    logic signed [63:0] p_reg;

    assign ua = a[63] ? 64'(-a) : 64'(a);
    assign ub = b[63] ? 64'(-b) : 64'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= a[63] ^ b[63];
            p00_reg <= {32'b0, ua[31:0]} * {32'b0, ub[31:0]};
            p01_reg <= {32'b0, ua[31:0]} * {32'b0, ub[63:32]};
            p10_reg <= {32'b0, ua[63:32]} * {32'b0, ub[31:0]};
            p11_reg <= {32'b0, ua[63:32]} * {32'b0, ub[63:32]};
        end
    end

    always_comb
    begin
        mid = {2'b0, p00_reg[63:32]} + {2'b0, p01_reg[31:0]} + {2'b0, p10_reg[31:0]};
        hi  = {2'b0, p11_reg} + {34'b0, p01_reg[63:32]} + {34'b0, p10_reg[63:32]}
            + {64'b0, mid[33:32]};
        mag = {hi[31:0], mid[31:0]};
        if (|hi[65:32])
        begin
            p_next = neg_reg ? Q_MIN : Q_MAX;
        end
        else
        begin
            p_next = from_mag(mag, neg_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- hdl/mcg_qdiv.sv -----
// mcg_qdiv: pipelined restoring Q32.32 divider, one quotient bit per stage, saturating
// depends on mcg_pkg
`default_nettype none

module mcg_qdiv (
    input  logic              clk,
    input  logic              en,
    input  logic signed [63:0] n,
    input  logic signed [63:0] d,
    output logic signed [63:0] q,
    output logic              zero
);
    import mcg_pkg::*;

    div_stage_t         stg_reg [DIV_STEPS+1];
    div_stage_t         stg_in;
    logic signed [63:0] q_reg;
    logic               zero_reg;
    div_stage_t         last;

    always_comb
    begin
        stg_in      = '0;
        stg_in.un   = n[63] ? 64'(-n) : 64'(n);
        stg_in.ud   = d[63] ? 64'(-d) : 64'(d);
        stg_in.neg  = n[63] ^ d[63];
        stg_in.zero = (d == 64'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= stg_in;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        localparam int BIT_POS = DIV_STEPS - 1 - j;
        logic        num_bit;
        logic [63:0] rs;
        logic        ge;
        div_stage_t  nxt;

        if (BIT_POS >= 32)
        begin : g_num
            assign num_bit = stg_reg[j].un[BIT_POS-32];
        end
        else
        begin : g_pad
            assign num_bit = 1'b0;
        end

        assign rs = {stg_reg[j].r[62:0], num_bit};
        assign ge = (rs >= stg_reg[j].ud);

        if (BIT_POS >= 64)
        begin : g_over
            always_comb
            begin
                nxt      = stg_reg[j];
                nxt.r    = ge ? rs - stg_reg[j].ud : rs;
                nxt.over = stg_reg[j].over | ge;
            end
        end
        else
        begin : g_quo
            always_comb
            begin
                nxt            = stg_reg[j];
                nxt.r          = ge ? rs - stg_reg[j].ud : rs;
                nxt.q[BIT_POS] = ge;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[j+1] <= nxt;
            end
        end
    end

    assign last = stg_reg[DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= last.zero;
            if (last.zero)
            begin
                q_reg <= 64'sd0;
            end
            else
            begin
                q_reg <= from_mag(last.over ? 64'hffff_ffff_ffff_ffff : last.q, last.neg);
            end
        end
    end

    assign q    = q_reg;
    assign zero = zero_reg;

endmodule

`default_nettype wire

// ----- hdl/mc_call_payoff_greeks.sv -----
// mc_call_payoff_greeks: discounted call payoff and greek estimates per simulated path
// depends on mcg_pkg, mcg_path_if, mcg_greek_if, mcg_qmul, mcg_qdiv
// pipeline: between request accept and result valid lie the input register, one divider,
// four multiplier levels, an add register and the output register
// throughput: one path per cycle; the whole pipeline holds while the output register is stalled
// reset: clears all valid bits and restores every configuration register to its reset value
`default_nettype none

module mc_call_payoff_greeks (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mcg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]     cfg_data,
    mcg_path_if.sink                           path,
    mcg_greek_if.source                        greeks
);
    import mcg_pkg::*;

    localparam int TM     = LAT_MUL;
    localparam int TD     = LAT_DIV;
    localparam int T_LAST = 4 * TM + TD + 1;
    localparam int T_OUT  = T_LAST + 1;
    localparam int T_SKP  = T_LAST - TM - 2;
    localparam int T_DIN  = T_LAST - TM - TD;
    localparam int T_G0   = T_DIN - 3 * TM;
    localparam int T_SKR  = T_LAST - 2 * TM - 1;

    logic [62:0]        strike_reg;
    logic [62:0]        maturity_reg;
    logic signed [63:0] rate_reg;
    logic [62:0]        df_reg;
    logic               mode_reg;

    logic               adv;
    logic [T_OUT:0]     vld_reg;
    side_t              side_reg [T_LAST+1];
    side_t              side_in;

    logic signed [63:0] k_s;
    logic signed [63:0] t_s;
    logic signed [63:0] df_s;
    logic signed [63:0] negt;

    logic signed [63:0] m_kr;
    logic signed [63:0] m_tt;
    logic signed [63:0] c_q;
    logic               theta_zero_unused;
    logic signed [63:0] cv;
    logic signed [63:0] ch;
    logic signed [63:0] cs;
    logic signed [63:0] vv;
    logic signed [63:0] ha;
    logic signed [63:0] hb;
    logic signed [63:0] x1_reg;
    logic signed [63:0] x2_reg;
    logic signed [63:0] xd;

    logic signed [63:0] skp_reg;
    logic signed [63:0] p1;
    logic signed [63:0] sdf;
    logic signed [63:0] pay4_reg;
    logic signed [63:0] pay_reg;

    logic signed [63:0] dq;
    logic               delta_zero_unused;
    logic signed [63:0] dd;

    logic signed [63:0] s0s0;
    logic signed [63:0] den1;
    logic signed [63:0] den;
    logic signed [63:0] wk;
    logic signed [63:0] gx;
    logic               gz;
    logic signed [63:0] gm;
    logic [TM-1:0]      fault_reg;

    logic signed [63:0] vt;
    logic signed [63:0] sub1_reg;
    logic signed [63:0] vm;
    logic signed [63:0] vd;

    logic signed [63:0] skr_reg;
    logic signed [63:0] skt;
    logic signed [63:0] ts;
    logic signed [63:0] rx_reg;
    logic signed [63:0] rd;

    greeks_t            out_reg;
    greeks_t            out_next;
    logic               itm_l;
    logic               flt_l;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strike_reg   <= '0;
            maturity_reg <= Q_ONE;
            rate_reg     <= 64'sd0;
            df_reg       <= Q_ONE;
            mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STRIKE:   strike_reg   <= cfg_data[62:0];
                CFG_MATURITY: maturity_reg <= cfg_data[62:0];
                CFG_RATE:     rate_reg     <= signed'(cfg_data);
                CFG_DISCOUNT: df_reg       <= cfg_data[62:0];
                CFG_MODE:     mode_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign k_s  = uq(strike_reg);
    assign t_s  = uq(maturity_reg);
    assign df_s = uq(df_reg);
    assign negt = -t_s;

    // pipeline control
    assign adv        = !vld_reg[T_OUT] || greeks.ready;
    assign path.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[T_OUT-1:0], path.valid};
        end
    end

    always_comb
    begin
        side_in.s   = path.data.terminal_price;
        side_in.s0  = path.data.start_price;
        side_in.v   = path.data.volatility;
        side_in.w   = path.data.brownian_value;
        side_in.itm = (path.data.terminal_price > strike_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i <= T_LAST; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // constant products of configuration
    mcg_qmul u_kr (.clk(clk), .en(adv), .a(k_s), .b(rate_reg), .p(m_kr));
    mcg_qmul u_tt (.clk(clk), .en(adv), .a(t_s), .b(t_s), .p(m_tt));

    // theta
    mcg_qdiv u_divc (.clk(clk), .en(adv), .n(side_reg[0].w), .d(m_tt), .q(c_q),
                     .zero(theta_zero_unused));
    mcg_qmul u_cv (.clk(clk), .en(adv), .a(c_q), .b(uq(side_reg[TD].v)), .p(cv));
    mcg_qmul u_ch (.clk(clk), .en(adv), .a(cv), .b(Q_HALF), .p(ch));
    mcg_qmul u_cs (.clk(clk), .en(adv), .a(ch), .b(uq(side_reg[TD+2*TM].s)), .p(cs));
    mcg_qmul u_vv (.clk(clk), .en(adv), .a(uq(side_reg[TD-1].v)), .b(uq(side_reg[TD-1].v)),
                   .p(vv));
    mcg_qmul u_ha (.clk(clk), .en(adv), .a(Q_HALF), .b(vv), .p(ha));
    mcg_qmul u_hb (.clk(clk), .en(adv), .a(ha), .b(uq(side_reg[TD-1+2*TM].s)), .p(hb));
    mcg_qmul u_xd (.clk(clk), .en(adv), .a(x2_reg), .b(df_s), .p(xd));

    // payoff
    mcg_qmul u_p1 (.clk(clk), .en(adv), .a(skp_reg), .b(df_s), .p(p1));
    mcg_qmul u_sdf (.clk(clk), .en(adv), .a(uq(side_reg[T_SKP].s)), .b(df_s), .p(sdf));

    // delta
    mcg_qdiv u_divd (.clk(clk), .en(adv), .n(uq(side_reg[T_DIN].s)),
                     .d(uq(side_reg[T_DIN].s0)), .q(dq), .zero(delta_zero_unused));
    mcg_qmul u_dd (.clk(clk), .en(adv), .a(dq), .b(df_s), .p(dd));

    // gamma
    mcg_qmul u_s0s0 (.clk(clk), .en(adv), .a(uq(side_reg[T_G0].s0)),
                     .b(uq(side_reg[T_G0].s0)), .p(s0s0));
    mcg_qmul u_den1 (.clk(clk), .en(adv), .a(s0s0), .b(t_s), .p(den1));
    mcg_qmul u_den (.clk(clk), .en(adv), .a(den1), .b(uq(side_reg[T_G0+2*TM].v)), .p(den));
    mcg_qmul u_wk (.clk(clk), .en(adv), .a(side_reg[T_DIN-TM].w), .b(k_s), .p(wk));
    mcg_qdiv u_divg (.clk(clk), .en(adv), .n(wk), .d(den), .q(gx), .zero(gz));
    mcg_qmul u_gm (.clk(clk), .en(adv), .a(gx), .b(df_s), .p(gm));

    // vega
    mcg_qmul u_vt (.clk(clk), .en(adv), .a(uq(side_reg[T_LAST-3*TM-1].v)), .b(t_s), .p(vt));
    mcg_qmul u_vm (.clk(clk), .en(adv), .a(uq(side_reg[T_LAST-2*TM].s)), .b(sub1_reg), .p(vm));
    mcg_qmul u_vd (.clk(clk), .en(adv), .a(vm), .b(df_s), .p(vd));

    // rho
    mcg_qmul u_skt (.clk(clk), .en(adv), .a(skr_reg), .b(negt), .p(skt));
    mcg_qmul u_ts (.clk(clk), .en(adv), .a(t_s), .b(uq(side_reg[T_SKR].s)), .p(ts));
    mcg_qmul u_rd (.clk(clk), .en(adv), .a(rx_reg), .b(df_s), .p(rd));

    // add stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg   <= sat_sub(m_kr, hb);
            x2_reg   <= sat_add(x1_reg, cs);
            skp_reg  <= side_reg[T_SKP-1].itm ?
                        uq(side_reg[T_SKP-1].s) - k_s : 64'sd0;
            pay4_reg <= mode_reg ? sat_sub(p1, sdf) : p1;
            pay_reg  <= mode_reg ? sat_add(pay4_reg, uq(side_reg[T_SKP+TM+1].s0)) : pay4_reg;
            sub1_reg <= sat_sub(side_reg[T_LAST-2*TM-1].w, vt);
            skr_reg  <= side_reg[T_SKR-1].itm ?
                        uq(side_reg[T_SKR-1].s) - k_s : 64'sd0;
            rx_reg   <= sat_add(skt, ts);
            fault_reg[0] <= gz;
            for (int i = 1; i < TM; i++)
            begin
                fault_reg[i] <= fault_reg[i-1];
            end
        end
    end

    // output register
    assign itm_l = side_reg[T_LAST].itm;
    assign flt_l = fault_reg[TM-1];

    always_comb
    begin
        out_next.payoff       = pay_reg;
        out_next.delta        = itm_l ? dd : 64'sd0;
        out_next.gamma        = (itm_l && !flt_l) ? gm : 64'sd0;
        out_next.vega         = itm_l ? vd : 64'sd0;
        out_next.theta        = itm_l ? sat_neg(xd) : 64'sd0;
        out_next.rho          = itm_l ? rd : 64'sd0;
        out_next.divide_fault = itm_l && flt_l;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign greeks.valid = vld_reg[T_OUT];
    assign greeks.data  = out_reg;

    a_fault_gamma: assert property (@(posedge clk) disable iff (!rst_n)
        greeks.valid && greeks.data.divide_fault |-> greeks.data.gamma == 64'sd0)
        else $error("gamma not zero on divide fault");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        path.valid && path.ready |=> vld_reg[0])
        else $error("accepted request did not enter pipeline");

    a_last_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[T_LAST] && adv |=> greeks.valid)
        else $error("result lost before output register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ----- tb/mcg_greeks_checker.sv -----
// mcg_greeks_checker: watches the config port and both channels of mc_call_payoff_greeks,
// predicts each path's payoff and greeks in Q32.32 and compares them with the results
// depends on mcg_pkg, mcg_path_if, mcg_greek_if
`default_nettype none

module mcg_greeks_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mcg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mcg_pkg::CFG_DATA_W-1:0]  cfg_data,
    mcg_path_if                             path,
    mcg_greek_if                            greeks,
    output int                              pending,
    output int                              errors
);
    import mcg_pkg::*;

    typedef logic signed [63:0] q_t;

    logic [62:0] k_reg;
    logic [62:0] t_reg;
    q_t          r_reg;
    logic [62:0] df_reg;
    logic        cv_mode;
    greeks_t     expected_greeks[$];

    function automatic logic [63:0] mag(input q_t a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic q_t signed_of(input logic [63:0] m, input logic neg);
        q_t res;
        if (!neg)
        begin
            res = m[63] ? Q_MAX : q_t'(m);
        end
        else
        begin
            res = (m >= 64'h8000_0000_0000_0000) ? Q_MIN : -q_t'(m);
        end
        return res;
    endfunction

    function automatic q_t q_sum(input q_t a, input q_t b);
        logic [64:0] x;
        x = {a[63], a} + {b[63], b};
        return (x[64] != x[63]) ? (x[64] ? Q_MIN : Q_MAX) : q_t'(x[63:0]);
    endfunction

    function automatic q_t q_diff(input q_t a, input q_t b);
        logic [64:0] x;
        x = {a[63], a} - {b[63], b};
        return (x[64] != x[63]) ? (x[64] ? Q_MIN : Q_MAX) : q_t'(x[63:0]);
    endfunction

    function automatic q_t q_negate(input q_t a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

    function automatic q_t q_prod(input q_t a, input q_t b);
        logic [127:0] p;
        logic         neg;
        neg = a[63] != b[63];
        p = {64'b0, mag(a)} * {64'b0, mag(b)};
        if (p[127:96] != 0)
        begin
            return neg ? Q_MIN : Q_MAX;
        end
        return signed_of(p[95:32], neg);
    endfunction

    function automatic q_t q_quot(input q_t n, input q_t d, output logic by_zero);
        logic [127:0] num;
        logic [127:0] quo;
        logic         neg;
        neg = n[63] != d[63];
        by_zero = (d == 0);
        if (d == 0)
        begin
            return 0;
        end
        num = {32'b0, mag(n), 32'b0};
        quo = num / {64'b0, mag(d)};
        return signed_of((quo[127:64] != 0) ? 64'hffff_ffff_ffff_ffff : quo[63:0], neg);
    endfunction

    function automatic greeks_t path_greeks(input path_t p);
        greeks_t g;
        q_t      s, s0, v, w, k, t, df, x, den;
        logic    z;
        logic    fault;
        s  = q_t'({1'b0, p.terminal_price});
        s0 = q_t'({1'b0, p.start_price});
        v  = q_t'({1'b0, p.volatility});
        w  = p.brownian_value;
        k  = q_t'({1'b0, k_reg});
        t  = q_t'({1'b0, t_reg});
        df = q_t'({1'b0, df_reg});
        g = '0;
        fault = 1'b0;
        g.payoff = q_prod((s > k) ? s - k : 0, df);
        if (cv_mode)
        begin
            g.payoff = q_sum(q_diff(g.payoff, q_prod(s, df)), s0);
        end
        if (s > k)
        begin
            g.delta = q_prod(q_quot(s, s0, z), df);
            den = q_prod(q_prod(q_prod(s0, s0), t), v);
            x = q_quot(q_prod(w, k), den, fault);
            g.gamma = fault ? 0 : q_prod(x, df);
            g.vega = q_prod(q_prod(s, q_diff(w, q_prod(v, t))), df);
            x = q_prod(k, r_reg);
            x = q_diff(x, q_prod(q_prod(Q_HALF, q_prod(v, v)), s));
            x = q_sum(x, q_prod(q_prod(q_prod(q_quot(w, q_prod(t, t), z), v), Q_HALF), s));
            g.theta = q_negate(q_prod(x, df));
            x = q_sum(q_prod(s - k, q_negate(t)), q_prod(t, s));
            g.rho = q_prod(x, df);
        end
        g.divide_fault = fault;
        return g;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        greeks_t want;
        if (!rst_n)
        begin
            k_reg   = '0;
            t_reg   = Q_ONE;
            r_reg   = '0;
            df_reg  = Q_ONE;
            cv_mode = 1'b0;
            errors  = 0;
            expected_greeks.delete();
            pending <= 0;
        end
        else
        begin
            if (path.valid && path.ready)
            begin
                expected_greeks.push_back(path_greeks(path.data));
            end
            if (greeks.valid && greeks.ready)
            begin
                if (expected_greeks.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_greeks.pop_front();
                    check_field("payoff", want.payoff, greeks.data.payoff);
                    check_field("delta", want.delta, greeks.data.delta);
                    check_field("gamma", want.gamma, greeks.data.gamma);
                    check_field("vega", want.vega, greeks.data.vega);
                    check_field("theta", want.theta, greeks.data.theta);
                    check_field("rho", want.rho, greeks.data.rho);
                    check_field("divide_fault", 64'(want.divide_fault),
                                64'(greeks.data.divide_fault));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STRIKE:   k_reg   = cfg_data[62:0];
                    CFG_MATURITY: t_reg   = cfg_data[62:0];
                    CFG_RATE:     r_reg   = cfg_data;
                    CFG_DISCOUNT: df_reg  = cfg_data[62:0];
                    CFG_MODE:     cv_mode = cfg_data[0];
                    default:      ;
                endcase
            end
            pending <= expected_greeks.size();
        end
    end
endmodule

`default_nettype wire

// ----- tb/tb_mc_call_payoff_greeks.sv -----
// tb_mc_call_payoff_greeks: drives directed and random paths through several register
// settings with random idling on both channels; the verdict comes from mcg_greeks_checker
// depends on mcg_pkg, mcg_path_if, mcg_greek_if, mc_call_payoff_greeks, mcg_greeks_checker
`default_nettype none

module tb_mc_call_payoff_greeks;
    import mcg_pkg::*;

    localparam int                     CYCLE_LIMIT = 400000;
    localparam int                     DRAIN_CYCLES = 130;
    localparam int                     HOLD_CYCLES = 400;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;
    localparam logic [62:0]            Q63_MAX = {63{1'b1}};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     pending;
    int                     errors;
    int                     cycles;
    logic                   sink_hold;
    logic                   idle_on;

    mcg_path_if  path ();
    mcg_greek_if greeks ();

    mc_call_payoff_greeks DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .path      (path),
        .greeks    (greeks)
    );

    mcg_greeks_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .path      (path),
        .greeks    (greeks),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_mc_call_payoff_greeks: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [62:0] rand_price(input int kind);
        logic [62:0] x;
        case (kind)
            0: x = 63'({$urandom, $urandom});
            1: x = {31'($urandom_range(0, 3)), $urandom};
            2: x = {31'($urandom_range(0, 199)), $urandom};
            3: x = '0;
            default: x = Q63_MAX;
        endcase
        return x;
    endfunction

    function automatic path_t random_path();
        path_t p;
        p.terminal_price = rand_price(($urandom_range(0, 9) < 7) ? 2 : $urandom_range(0, 4));
        p.start_price    = rand_price(($urandom_range(0, 9) < 7) ? 2 : $urandom_range(0, 4));
        p.volatility     = rand_price(($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 4));
        if ($urandom_range(0, 9) < 7)
        begin
            p.brownian_value = {{31{1'b0}}, 33'($urandom_range(0, 3)) << 32 | 33'($urandom)};
            if ($urandom_range(0, 1))
            begin
                p.brownian_value = -p.brownian_value;
            end
        end
        else
        begin
            p.brownian_value = {$urandom, $urandom};
        end
        return p;
    endfunction

    // one request per call; the gap before it is drawn fresh
    task automatic send_path(input path_t p);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            path.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        path.valid <= 1'b1;
        path.data  <= p;
        @(posedge clk);
        while (!path.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic mk_send(input logic [62:0] s, input logic [62:0] s0, input logic [62:0] v,
                           input logic signed [63:0] w);
        path_t p;
        p.terminal_price = s;
        p.start_price    = s0;
        p.volatility     = v;
        p.brownian_value = w;
        send_path(p);
    endtask

    task automatic drain();
        path.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // result side: per-result stall, plus one long hold-off on request
    initial
    begin
        int   n;
        logic held;
        held = 1'b0;
        greeks.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (sink_hold && !held)
            begin
                greeks.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else
            begin
                n = idle_on ? $urandom_range(0, 9) : 0;
                if (n > 0)
                begin
                    greeks.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            greeks.ready <= 1'b1;
            @(posedge clk);
            while (!greeks.valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        path_t p;
        path.valid = 1'b0;
        path.data  = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        sink_hold  = 1'b0;
        idle_on    = 1'b1;
        rst_n      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: strike 0, maturity 1.0, discount 1.0
        mk_send('0, '0, '0, '0);
        mk_send(Q63_MAX, Q63_MAX, Q63_MAX, Q_MAX);
        mk_send(Q63_MAX, 63'h1_0000_0000, 63'h0_8000_0000, Q_MIN);
        mk_send(63'h5_0000_0000, '0, 63'h0_4000_0000, 64'sh1_0000_0000);
        mk_send(63'h5_0000_0000, 63'h4_0000_0000, '0, -64'sh2_0000_0000);
        mk_send(63'h1, 63'h1, 63'h1, 64'sh1);
        drain();

        write_reg(CFG_STRIKE, 64'h0000_0064_0000_0000);
        write_reg(CFG_RATE, 64'h0000_0000_0ccc_cccd);
        write_reg(CFG_DISCOUNT, 64'h0000_0000_f000_0000);
        write_reg(CFG_MODE, 64'h1);
        write_reg(UNUSED_INDEX, 64'hffff_ffff_ffff_ffff);
        mk_send(63'h64_0000_0000, 63'h64_0000_0000, 63'h0_3333_3333, 64'sh1_0000_0000);
        mk_send(63'h64_0000_0001, 63'h64_0000_0000, 63'h0_3333_3333, -64'sh1_0000_0000);
        mk_send(63'h78_0000_0000, 63'h64_0000_0000, 63'h0_3333_3333, 64'sh0_8000_0000);
        mk_send('0, 63'h64_0000_0000, 63'h0_3333_3333, '0);
        mk_send(63'h78_0000_0000, '0, 63'h0_3333_3333, Q_MAX);
        mk_send(63'h78_0000_0000, 63'h64_0000_0000, '0, Q_MIN);
        mk_send(Q63_MAX, Q63_MAX, Q63_MAX, Q_MIN);
        drain();

        // zero maturity: gamma divisor and theta divisor both zero
        write_reg(CFG_MATURITY, 64'h0);
        mk_send(63'h78_0000_0000, 63'h64_0000_0000, 63'h0_3333_3333, 64'sh1_0000_0000);
        mk_send(63'h78_0000_0000, 63'h64_0000_0000, 63'h0_3333_3333, -64'sh1_0000_0000);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_STRIKE, 64'h0000_0064_0000_0000);
                    write_reg(CFG_MATURITY, 64'h0000_0001_0000_0000);
                    write_reg(CFG_RATE, 64'h0000_0000_0ccc_cccd);
                    write_reg(CFG_DISCOUNT, 64'h0000_0000_f333_3333);
                    write_reg(CFG_MODE, 64'h0);
                end
                1:
                begin
                    write_reg(CFG_MODE, 64'h1);
                    write_reg(CFG_RATE, 64'({$urandom, $urandom}));
                    write_reg(CFG_MATURITY, 64'({$urandom_range(0, 3), $urandom}));
                end
                2:
                begin
                    write_reg(CFG_STRIKE, 64'hffff_ffff_ffff_ffff);
                    write_reg(CFG_RATE, Q_MAX);
                    write_reg(CFG_DISCOUNT, 64'hffff_ffff_ffff_ffff);
                    write_reg(CFG_MATURITY, 64'hffff_ffff_ffff_ffff);
                end
                3:
                begin
                    write_reg(CFG_STRIKE, 64'h0);
                    write_reg(CFG_RATE, Q_MIN);
                    write_reg(CFG_DISCOUNT, 64'h0);
                    write_reg(CFG_MODE, 64'h0);
                end
                4:
                begin
                    write_reg(CFG_STRIKE, 64'({$urandom_range(0, 150), $urandom}));
                    write_reg(CFG_MATURITY, 64'({$urandom_range(0, 2), $urandom}));
                    write_reg(CFG_RATE, 64'(-64'sh0_1000_0000));
                    write_reg(CFG_DISCOUNT, 64'({$urandom_range(0, 1), $urandom}));
                    write_reg(CFG_MODE, 64'h3);
                end
                default:
                begin
                    write_reg(CFG_STRIKE, 64'h0000_0050_0000_0000);
                    write_reg(CFG_MATURITY, 64'h0000_0000_8000_0000);
                    write_reg(CFG_DISCOUNT, 64'h0000_0000_fae1_47ae);
                end
            endcase
            for (int i = 0; i < 100; i++)
            begin
                if (i == 20)
                begin
                    idle_on = 1'b0;
                end
                if (i == 50)
                begin
                    idle_on = 1'b1;
                end
                if (phase == 1 && i == 60)
                begin
                    idle_on = 1'b0;
                    sink_hold = 1'b1;
                end
                if (phase == 1 && i == 90)
                begin
                    idle_on = 1'b1;
                end
                p = random_path();
                send_path(p);
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("tb_mc_call_payoff_greeks: done, clean");
        end
        else
        begin
            $display("tb_mc_call_payoff_greeks: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
